// ===== rtl/qkd_pkg.sv =====
// ----------------------------------------------------------------------------
// qkd_pkg
// Shared types, constants and helpers of the Q4_K super-block dequantizer.
// ----------------------------------------------------------------------------
package qkd_pkg;

    localparam int unsigned SB_BYTES    = 144;
    localparam int unsigned QUANT_START = 16;
    localparam int unsigned SUB_BYTES   = 12;
    localparam int unsigned GROUP_BYTES = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [31:0] NAN_BITS  = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
    localparam logic [31:0] NEG_ZERO  = 32'h8000_0000;
    localparam logic [4:0]  EXP_SPEC  = 5'd31;
    localparam logic [7:0]  EXP_TOP   = 8'd153;

    typedef struct packed {
        logic [5:0] sc;
        logic [5:0] mn;
    } sub_param_t;

    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] quants;
        logic [15:0]                 d;
        logic [15:0]                 dmin;
        sub_param_t                  lo;
        sub_param_t                  hi;
    } job_t;

    function automatic sub_param_t sub_params(input logic [SUB_BYTES-1:0][7:0] p,
                                              input logic [2:0] idx);
        sub_param_t r;
        logic [1:0] j;
        j = idx[1:0];
        if (!idx[2]) begin
            r.sc = p[j][5:0];
            r.mn = p[3'(j) + 3'd4][5:0];
        end else begin
            r.sc = {p[j][7:6], p[4'(j) + 4'd8][3:0]};
            r.mn = {p[3'(j) + 3'd4][7:6], p[4'(j) + 4'd8][7:4]};
        end
        return r;
    endfunction

endpackage

// ===== rtl/q4_k_superblock_dequantizer.sv =====
// ----------------------------------------------------------------------------
// q4_k_superblock_dequantizer
// Q4_K super-block dequantizer: 144-byte super-blocks in, binary32 values out.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle; the 32nd byte of each quant group pushes a job
// into a two-entry queue and stalls only while that queue is full. The compute
// side issues one value per cycle while a job is queued and the output is not
// stalled, up to 64 per group, through a five-stage pipeline into the output
// register, so a super-block of up to 256 values is bounded by the single
// value per cycle of the result pipeline. element_count may be written only
// while no transaction is in flight.
module q4_k_superblock_dequantizer #(
    parameter int unsigned QUEUE_DEPTH = qkd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_raw_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value_bits,
    output logic        m_last_of_run
);

    logic [31:0]   element_count_reg;
    logic          push, push_ready, pop, pop_valid;
    qkd_pkg::job_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= 32'd0;
        end else if (cfg_valid) begin
            element_count_reg <= cfg_data;
        end
    end

    qkd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_raw_byte (s_raw_byte),
        .job_push   (push),
        .job_data   (push_data),
        .job_ready  (push_ready)
    );

    qkd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid)
    );

    qkd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .element_count (element_count_reg),
        .job_valid     (pop_valid),
        .job_data      (pop_data),
        .job_pop       (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_value_bits  (m_value_bits),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== rtl/qkd_front.sv =====
// ----------------------------------------------------------------------------
// qkd_front
// Byte intake: tracks the super-block offset, holds the header fields and the
// current quant group, and hands a complete group to the job queue.
// ----------------------------------------------------------------------------
module qkd_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_raw_byte,
    output logic          job_push,
    output qkd_pkg::job_t job_data,
    input  logic          job_ready
);

    logic [7:0] pos_reg, pos_next;
    logic [15:0] d_reg;
    logic [15:0] dmin_reg;
    logic [qkd_pkg::SUB_BYTES-1:0][7:0] sub_reg;
    logic [7:0] quant_reg [qkd_pkg::GROUP_BYTES-1];

    logic       in_quant;
    logic [7:0] off;
    logic [4:0] idx;
    logic [1:0] grp;
    logic       group_end;
    logic       accept;
    logic [3:0] sub_idx;

    assign in_quant  = pos_reg >= 8'(qkd_pkg::QUANT_START);
    assign off       = pos_reg - 8'(qkd_pkg::QUANT_START);
    assign idx       = off[4:0];
    assign grp       = off[6:5];
    assign group_end = in_quant && (idx == 5'd31);
    assign sub_idx   = 4'(pos_reg - 8'd4);

    assign s_ready  = !group_end || job_ready;
    assign accept   = s_valid && s_ready;
    assign job_push = s_valid && group_end && job_ready;
    assign pos_next = (pos_reg == 8'(qkd_pkg::SB_BYTES - 1)) ? 8'd0 : pos_reg + 8'd1;

    always_comb begin
        for (int i = 0; i < qkd_pkg::GROUP_BYTES - 1; i++) begin
            job_data.quants[i] = quant_reg[i];
        end
        job_data.quants[qkd_pkg::GROUP_BYTES-1] = s_raw_byte;
        job_data.d    = d_reg;
        job_data.dmin = dmin_reg;
        job_data.lo   = qkd_pkg::sub_params(sub_reg, {grp, 1'b0});
        job_data.hi   = qkd_pkg::sub_params(sub_reg, {grp, 1'b1});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 8'd0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            case (pos_reg)
                8'd0: d_reg[7:0]     <= s_raw_byte;
                8'd1: d_reg[15:8]    <= s_raw_byte;
                8'd2: dmin_reg[7:0]  <= s_raw_byte;
                8'd3: dmin_reg[15:8] <= s_raw_byte;
                default: begin
                    if (!in_quant) begin
                        sub_reg[sub_idx] <= s_raw_byte;
                    end else if (!group_end) begin
                        quant_reg[idx] <= s_raw_byte;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/qkd_queue.sv =====
// ----------------------------------------------------------------------------
// qkd_queue
// Small first-word-fall-through job queue between intake and compute.
// ----------------------------------------------------------------------------
module qkd_queue #(
    parameter int unsigned DEPTH = qkd_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  qkd_pkg::job_t push_data,
    output logic          push_ready,
    input  logic          pop,
    output qkd_pkg::job_t pop_data,
    output logic          pop_valid
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    qkd_pkg::job_t mem [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign push_ready = cnt_reg != CW'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/qkd_back.sv =====
// ----------------------------------------------------------------------------
// qkd_back
// Walks the 64 values of a queued group, applies the element limit and runs
// the five-stage d*sc*q - dmin*m pipeline into the output register.
// ----------------------------------------------------------------------------
module qkd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [31:0]   element_count,
    input  logic          job_valid,
    input  qkd_pkg::job_t job_data,
    output logic          job_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_value_bits,
    output logic          m_last_of_run
);

    logic        adv;
    logic [5:0]  k_reg;
    logic [31:0] emitted_reg;
    logic        ok, at_end, issue, done;
    logic [7:0]  qb;
    logic [3:0]  q;
    qkd_pkg::sub_param_t sp;

    assign adv    = !m_valid || m_ready;
    assign ok     = emitted_reg < element_count;
    assign at_end = (k_reg == 6'd63) || ({1'b0, emitted_reg} + 33'd1 == {1'b0, element_count});
    assign issue  = job_valid && adv && ok;
    assign done   = job_valid && adv && (!ok || at_end);
    assign job_pop = done;

    assign qb = job_data.quants[k_reg[4:0]];
    assign q  = k_reg[5] ? qb[7:4] : qb[3:0];
    assign sp = k_reg[5] ? job_data.hi : job_data.lo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= 6'd0;
            emitted_reg <= 32'd0;
        end else begin
            if (done) begin
                k_reg <= 6'd0;
            end else if (issue) begin
                k_reg <= k_reg + 6'd1;
            end
            if (issue) begin
                emitted_reg <= emitted_reg + 32'd1;
            end
        end
    end

    // stage 1: integer factor
    logic        v1, last1;
    logic [9:0]  ka1;
    logic [5:0]  mn1;
    logic [15:0] d1, dm1;

    // stage 2: exact products
    logic        v2, last2, sa2, sb2, nana2, infa2, nanb2, infb2;
    logic [20:0] maga2;
    logic [16:0] magb2;
    logic [4:0]  sha2, shb2;

    logic [4:0]  exa, exb;
    logic [10:0] manta, mantb;

    assign exa   = d1[14:10];
    assign exb   = dm1[14:10];
    assign manta = {exa != 5'd0, d1[9:0]};
    assign mantb = {exb != 5'd0, dm1[9:0]};

    // stage 3: aligned difference
    logic        v3, last3, spec3, sign3;
    logic [31:0] specbits3;
    logic [50:0] mag3;

    logic [50:0] va, vb;
    logic [51:0] sa, sb;
    logic [52:0] diff;
    logic [52:0] adiff;
    logic        spec;
    logic [31:0] specbits;

    always_comb begin
        va = 51'(maga2) << sha2;
        vb = 51'(magb2) << shb2;
        sa = sa2 ? -{1'b0, va} : {1'b0, va};
        sb = sb2 ? -{1'b0, vb} : {1'b0, vb};
        diff  = {sa[51], sa} - {sb[51], sb};
        adiff = diff[52] ? -diff : diff;
        spec = 1'b1;
        specbits = 32'd0;
        if (nana2 || nanb2) begin
            specbits = qkd_pkg::NAN_BITS;
        end else if (infa2 && infb2) begin
            specbits = (sa2 == sb2) ? qkd_pkg::NAN_BITS : {sa2, qkd_pkg::INF_MAG};
        end else if (infa2) begin
            specbits = {sa2, qkd_pkg::INF_MAG};
        end else if (infb2) begin
            specbits = {!sb2, qkd_pkg::INF_MAG};
        end else if (maga2 == '0 && magb2 == '0) begin
            specbits = (sa2 && !sb2) ? qkd_pkg::NEG_ZERO : 32'd0;
        end else if (diff == '0) begin
            specbits = 32'd0;
        end else begin
            spec = 1'b0;
        end
    end

    // stage 4: leading zero count
    logic        v4, last4, spec4, sign4;
    logic [31:0] specbits4;
    logic [50:0] mag4;
    logic [5:0]  lz4;
    logic [5:0]  lz;
    logic        found;

    always_comb begin
        lz = 6'd0;
        found = 1'b0;
        for (int i = 50; i >= 0; i--) begin
            if (!found && mag3[i]) begin
                lz = 6'(50 - i);
                found = 1'b1;
            end
        end
    end

    // stage 5: normalize, round, pack
    logic [50:0] norm;
    logic        rnd;
    logic [24:0] m;
    logic [7:0]  bexp;
    logic [31:0] packed_bits;

    always_comb begin
        norm = mag4 << lz4;
        rnd  = norm[26] && ((|norm[25:0]) || norm[27]);
        m    = {1'b0, norm[50:27]} + 25'(rnd);
        bexp = qkd_pkg::EXP_TOP - 8'(lz4) + 8'(m[24]);
        packed_bits = spec4 ? specbits4 : {sign4, bexp, m[24] ? 23'd0 : m[22:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1 <= 1'b0;
            v2 <= 1'b0;
            v3 <= 1'b0;
            v4 <= 1'b0;
            m_valid <= 1'b0;
        end else if (adv) begin
            v1 <= issue;
            v2 <= v1;
            v3 <= v2;
            v4 <= v3;
            m_valid <= v4;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ka1   <= 10'(sp.sc) * 10'(q);
            mn1   <= sp.mn;
            d1    <= job_data.d;
            dm1   <= job_data.dmin;
            last1 <= at_end;

            maga2 <= 21'(manta) * 21'(ka1);
            magb2 <= 17'(mantb) * 17'(mn1);
            sha2  <= (exa == 5'd0) ? 5'd0 : exa - 5'd1;
            shb2  <= (exb == 5'd0) ? 5'd0 : exb - 5'd1;
            sa2   <= d1[15];
            sb2   <= dm1[15];
            nana2 <= (exa == qkd_pkg::EXP_SPEC) && (d1[9:0] != '0 || ka1 == '0);
            infa2 <= (exa == qkd_pkg::EXP_SPEC) && d1[9:0] == '0 && ka1 != '0;
            nanb2 <= (exb == qkd_pkg::EXP_SPEC) && (dm1[9:0] != '0 || mn1 == '0);
            infb2 <= (exb == qkd_pkg::EXP_SPEC) && dm1[9:0] == '0 && mn1 != '0;
            last2 <= last1;

            spec3     <= spec;
            specbits3 <= specbits;
            sign3     <= diff[52];
            mag3      <= adiff[50:0];
            last3     <= last2;

            spec4     <= spec3;
            specbits4 <= specbits3;
            sign4     <= sign3;
            mag4      <= mag3;
            lz4       <= lz;
            last4     <= last3;

            m_value_bits  <= packed_bits;
            m_last_of_run <= last4;
        end
    end

endmodule

// ===== rtl/qkd_checker.sv =====
// ----------------------------------------------------------------------------
// qkd_checker
// Port-level checks of the dequantizer output stream.
// ----------------------------------------------------------------------------
module qkd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_value_bits,
    input logic        m_last_of_run
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_bits) && $stable(m_last_of_run))
        else $error("output transaction changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_value_bits[30:23] == 8'hFF && m_value_bits[22:0] != 23'd0
        |-> m_value_bits == 32'h7FC0_0000)
        else $error("non-canonical NaN");

    a_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_value_bits[30:23] == 8'h00 |-> m_value_bits[22:0] == 23'd0)
        else $error("subnormal result");

endmodule

bind q4_k_superblock_dequantizer qkd_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_value_bits  (m_value_bits),
    .m_last_of_run (m_last_of_run)
);

// ===== dv/tb_q4_k_superblock_dequantizer.sv =====
// ----------------------------------------------------------------------------
// tb_q4_k_superblock_dequantizer
// Self-checking bench for the Q4_K super-block dequantizer. Super-block byte
// streams go in over the byte channel; a scoreboard class decodes each byte,
// works out the binary32 values it releases and checks the result channel in
// order. Runs pass through idle and stall phases and several element_count
// settings, including zero, a partial count and the largest count.
// ----------------------------------------------------------------------------
module tb_q4_k_superblock_dequantizer;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int          PHASE_BYTES    = 120;

    typedef struct {
        logic [31:0] value_bits;
        logic        last_of_run;
    } dq_value_t;

    class dequant_scoreboard;
        logic [31:0] element_count;
        logic [7:0]  byte_pos;
        logic [15:0] d_half;
        logic [15:0] dmin_half;
        logic [7:0]  subscale_bytes [qkd_pkg::SUB_BYTES];
        logic [7:0]  quant_bytes [qkd_pkg::GROUP_BYTES];
        logic [31:0] emitted;
        dq_value_t   pending [$];
        int          mismatches;
        int          checked;

        function new();
            element_count = 0;
            byte_pos = 0;
            emitted = 0;
            mismatches = 0;
            checked = 0;
            d_half = 0;
            dmin_half = 0;
            foreach (subscale_bytes[i]) subscale_bytes[i] = 0;
            foreach (quant_bytes[i]) quant_bytes[i] = 0;
        endfunction

        function void unpack_sub(input int idx, output logic [5:0] sc, output logic [5:0] mn);
            if (idx < 4) begin
                sc = subscale_bytes[idx][5:0];
                mn = subscale_bytes[idx + 4][5:0];
            end else begin
                sc = {subscale_bytes[idx - 4][7:6], subscale_bytes[idx + 4][3:0]};
                mn = {subscale_bytes[idx][7:6], subscale_bytes[idx + 4][7:4]};
            end
        endfunction

        // kind: 0 finite, 1 inf, 2 nan; value = mag * 2^expo
        function void half_term(input logic [15:0] h, input logic [31:0] k, output int kind,
                                output bit sgn, output longint unsigned mag,
                                output int expo);
            logic [4:0] ex;
            logic [9:0] fr;
            ex = h[14:10];
            fr = h[9:0];
            sgn = h[15];
            kind = 0;
            mag = 0;
            expo = 0;
            if (ex == qkd_pkg::EXP_SPEC) begin
                kind = (fr != 0 || k == 0) ? 2 : 1;
            end else if (ex == 0) begin
                mag = longint'(fr) * k;
                expo = -24;
            end else begin
                mag = longint'(11'd1024 + fr) * k;
                expo = int'(ex) - 25;
            end
        endfunction

        function logic [31:0] round_to_single(input bit sgn, input longint unsigned mag,
                                              input int e);
            int n;
            int sh;
            longint unsigned m;
            longint unsigned rem;
            longint unsigned half;
            n = 0;
            m = mag;
            while (m != 0) begin
                n++;
                m >>= 1;
            end
            if (n > 24) begin
                sh = n - 24;
                rem = mag & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                m = mag >> sh;
                if (rem > half || (rem == half && m[0])) m++;
                if (m == (64'd1 << 24)) begin
                    m >>= 1;
                    sh++;
                end
                e += sh;
            end else begin
                m = mag << (24 - n);
                e -= 24 - n;
            end
            return {sgn, 8'(e + 150), m[22:0]};
        endfunction

        function logic [31:0] dequant(input logic [31:0] k_scale, input logic [31:0] k_min);
            int ka, kb, ea, eb, emin;
            bit sa, sb;
            longint unsigned ma, mb;
            longint va, vb, s;
            half_term(d_half, k_scale, ka, sa, ma, ea);
            half_term(dmin_half, k_min, kb, sb, mb, eb);
            if (ka == 2 || kb == 2) return qkd_pkg::NAN_BITS;
            if (ka == 1 && kb == 1) return (sa == sb) ? qkd_pkg::NAN_BITS : {sa, qkd_pkg::INF_MAG};
            if (ka == 1) return {sa, qkd_pkg::INF_MAG};
            if (kb == 1) return {~sb, qkd_pkg::INF_MAG};
            if (ma == 0 && mb == 0) return (sa && !sb) ? qkd_pkg::NEG_ZERO : 32'd0;
            emin = (ea < eb) ? ea : eb;
            va = longint'(ma << (ea - emin));
            vb = longint'(mb << (eb - emin));
            if (sa) va = -va;
            if (sb) vb = -vb;
            s = va - vb;
            if (s == 0) return 32'd0;
            return round_to_single(s < 0, (s < 0) ? longint'(-s) : s, emin);
        endfunction

        function void note_byte(input logic [7:0] b);
            int off, grp, nq, produced;
            logic [3:0] q;
            logic [5:0] sc, mn;
            dq_value_t v;
            produced = 0;
            if (byte_pos == 0) d_half[7:0] = b;
            else if (byte_pos == 1) d_half[15:8] = b;
            else if (byte_pos == 2) dmin_half[7:0] = b;
            else if (byte_pos == 3) dmin_half[15:8] = b;
            else if (byte_pos < qkd_pkg::QUANT_START) subscale_bytes[byte_pos - 4] = b;
            else begin
                off = byte_pos - qkd_pkg::QUANT_START;
                quant_bytes[off % qkd_pkg::GROUP_BYTES] = b;
                if (off % qkd_pkg::GROUP_BYTES == qkd_pkg::GROUP_BYTES - 1) begin
                    grp = off / qkd_pkg::GROUP_BYTES;
                    for (nq = 0; nq < 64; nq++) begin
                        if (emitted >= element_count) break;
                        q = (nq >= 32) ? quant_bytes[nq % 32][7:4] : quant_bytes[nq % 32][3:0];
                        unpack_sub(2 * grp + nq / 32, sc, mn);
                        v.value_bits = dequant(32'(sc) * q, 32'(mn));
                        v.last_of_run = 0;
                        pending.insert(pending.size(), v);
                        produced++;
                        emitted++;
                    end
                    if (produced > 0) pending[$].last_of_run = 1;
                end
            end
            byte_pos = (byte_pos + 1 >= qkd_pkg::SB_BYTES) ? 8'd0 : byte_pos + 8'd1;
        endfunction

        function void check_value(input logic [31:0] bits, input logic last);
            dq_value_t e;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected transaction value=%h last=%b", bits, last);
                return;
            end
            e = pending.pop_front();
            if (e.value_bits !== bits || e.last_of_run !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: value exp %h/%b got %h/%b", e.value_bits,
                             e.last_of_run, bits, last);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [7:0]  s_raw_byte = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_value_bits;
    logic        m_last_of_run;

    dequant_scoreboard sb = new();
    logic [7:0] blk [qkd_pkg::SB_BYTES];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;
    int bytes_sent = 0;

    always #5 aclk = ~aclk;

    q4_k_superblock_dequantizer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_raw_byte(s_raw_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_value_bits(m_value_bits), .m_last_of_run(m_last_of_run)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_value(m_value_bits, m_last_of_run);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: watchdog expired");
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // valid stays up between back-to-back bytes; callers drop it when done
    task automatic send_byte(input logic [7:0] b);
        case (bytes_sent / PHASE_BYTES)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_raw_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic write_count(input logic [31:0] n);
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.element_count = n;
        cfg_valid <= 0;
    endtask

    // header with given halves, then subscale and quant bytes by mode
    function automatic void make_block(input logic [15:0] d, input logic [15:0] dm,
                                       input int mode);
        blk[0] = d[7:0];
        blk[1] = d[15:8];
        blk[2] = dm[7:0];
        blk[3] = dm[15:8];
        for (int i = 4; i < qkd_pkg::SB_BYTES; i++) begin
            blk[i] = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom);
        end
    endfunction

    task automatic send_range(input int lo_idx, input int hi_idx);
        for (int i = lo_idx; i < hi_idx; i++) send_byte(blk[i]);
    endtask

    function automatic logic [15:0] rand_half();
        case ($urandom_range(7))
            0: return {1'($urandom), 5'd0, 10'($urandom)};
            1: return {1'($urandom), 5'd31, 10'd0};
            2: return {1'($urandom), 5'd31, 10'($urandom_range(1023, 1))};
            3: return {1'($urandom), 15'd0};
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // count zero: the first group may produce nothing
        make_block(16'h3C00, 16'h3800, 0);
        send_range(0, 48);
        write_count(32'd100);
        send_range(48, qkd_pkg::SB_BYTES);
        write_count(32'hFFFF_FFFF);
        make_block(16'h7BFF, 16'hFBFF, 1);
        send_range(0, qkd_pkg::SB_BYTES);
        write_count(sb.emitted + 32'd150);
        make_block(rand_half(), rand_half(), 0);
        send_range(0, qkd_pkg::SB_BYTES);
        write_count(32'hFFFF_FFFF);
        make_block(16'h0001, 16'h8001, 0);
        send_range(0, 48);

        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d byte and %0d value transactions over idle/stall phases",
                 bytes_sent, sb.checked);
        $display("Element counts exercised: 0, 100, partial and 0xFFFFFFFF");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/qkd_pkg.sv
rtl/qkd_front.sv
rtl/qkd_queue.sv
rtl/qkd_back.sv
rtl/q4_k_superblock_dequantizer.sv
rtl/qkd_checker.sv
dv/tb_q4_k_superblock_dequantizer.sv
